@@ design/mbw_pkg.sv @@
// Shared types, codes and helper functions of the maze walker.
package mbw_pkg;

	// Operation codes of an input item
	typedef logic [1:0] mbw_op_t;
	localparam mbw_op_t OP_START = 2'd0;
	localparam mbw_op_t OP_STEP  = 2'd1;
	localparam mbw_op_t OP_READ  = 2'd2;

	// Result status codes
	localparam logic [2:0] RS_STARTED     = 3'd0;
	localparam logic [2:0] RS_ADVANCED    = 3'd1;
	localparam logic [2:0] RS_BACKTRACKED = 3'd2;
	localparam logic [2:0] RS_FINISHED    = 3'd3;
	localparam logic [2:0] RS_READ_DONE   = 3'd4;

	// Configuration register indexes
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	// Cell entry: bit4 visited, bits 3:0 walls (bit0 top, bit1 right, bit2 bottom, bit3 left)
	localparam logic [3:0] WALLS_ALL  = 4'hF;
	localparam logic [4:0] VISIT_MASK = 5'h10;

	// Neighbour directions in search order
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_MUL,
		ST_DIV_START,
		ST_WAIT_START,
		ST_WIPE,
		ST_DIV_STEP,
		ST_WAIT_STEP,
		ST_VISIT,
		ST_NB_RD,
		ST_NB_EVAL,
		ST_PICK,
		ST_PUSH,
		ST_MOVE,
		ST_POP,
		ST_RES_RD,
		ST_EMIT
	} mbw_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic clr_step;
		logic mul;
		logic div_go;
		logic div_step;
		logic set_start;
		logic rd_cur;
		logic visit;
		logic nb_rd;
		logic nb_eval;
		logic pick;
		logic push;
		logic move;
		logic pop_rd;
		logic pop;
		logic finish;
		logic res_rd;
		logic emit;
	} mbw_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic done;
		logic clr_last;
		logic div_done;
		logic nb_last;
		logic n_zero;
		logic depth_zero;
		logic out_free;
	} mbw_sts_t;

	// Wall of the current cell that a move in direction d opens
	function automatic logic [3:0] here_wall(input logic [1:0] d);
		logic [3:0] w;
		case (d)
			DIR_UP:    w = 4'h1;
			DIR_LEFT:  w = 4'h8;
			DIR_DOWN:  w = 4'h4;
			DIR_RIGHT: w = 4'h2;
			default:   w = 4'h0;
		endcase
		return w;
	endfunction

	// Wall of the entered cell that a move in direction d opens
	function automatic logic [3:0] there_wall(input logic [1:0] d);
		logic [3:0] w;
		case (d)
			DIR_UP:    w = 4'h4;
			DIR_LEFT:  w = 4'h2;
			DIR_DOWN:  w = 4'h1;
			DIR_RIGHT: w = 4'h8;
			default:   w = 4'h0;
		endcase
		return w;
	endfunction

	// r mod 3: base-4 digit sum (4 = 1 mod 3), then fold
	function automatic logic [1:0] mod3(input logic [7:0] r);
		logic [3:0] s;
		s = {2'b00, r[1:0]} + {2'b00, r[3:2]} + {2'b00, r[5:4]} + {2'b00, r[7:6]};
		if (s >= 4'd12)
			s = s - 4'd12;
		else if (s >= 4'd9)
			s = s - 4'd9;
		else if (s >= 4'd6)
			s = s - 4'd6;
		else if (s >= 4'd3)
			s = s - 4'd3;
		return s[1:0];
	endfunction

	// Candidate index: r mod n for n in 1..4
	function automatic logic [1:0] pick_index(input logic [7:0] r, input logic [2:0] n);
		logic [1:0] k;
		case (n)
			3'd2:    k = {1'b0, r[0]};
			3'd3:    k = mod3(r);
			3'd4:    k = r[1:0];
			default: k = 2'd0;
		endcase
		return k;
	endfunction

endpackage

@@ design/mbw_if.sv @@
// Request and response channel interfaces of the maze walker.
interface mbw_req_if import mbw_pkg::*;;
	logic       valid;
	logic       ready;
	mbw_op_t    operation;
	logic [11:0] cell_address;
	logic [7:0] random_value;

	modport source (output valid, output operation, output cell_address,
		output random_value, input ready);
	modport sink (input valid, input operation, input cell_address,
		input random_value, output ready);
endinterface

interface mbw_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [11:0] cell_out;
	logic [3:0]  wall_bits;
	logic        visited_flag;

	modport source (output valid, output status, output cell_out, output wall_bits,
		output visited_flag, input ready);
	modport sink (input valid, input status, input cell_out, input wall_bits,
		input visited_flag, output ready);
endinterface

@@ design/mbw_ram.sv @@
// Generic single write port RAM with registered read.
module mbw_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

@@ design/mbw_div.sv @@
// Restoring divider, one quotient bit per cycle.
module mbw_div #(
	parameter int DW = 12,
	parameter int VW = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [VW-1:0] rem
);
	localparam int CNTW = $clog2(DW + 1);

	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [DW-1:0]   quo_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   dvs_q;
	logic [VW:0]     shifted;
	logic [VW:0]     diff;
	logic            ge;

	// trial subtraction
	assign shifted = {rem_q, quo_q[DW-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNTW'(1)) && !start;
			if (start)
				cnt_q <= CNTW'(DW);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[VW-1:0] : shifted[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule

@@ design/mbw_regs.sv @@
// APB configuration registers: grid column and row counts.
module mbw_regs import mbw_pkg::*; #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [6:0]  cols,
	output logic [6:0]  rows
);
	localparam logic [6:0] COLS_RST = (MAX_COLUMNS < 64) ? 7'(MAX_COLUMNS) : 7'd64;
	localparam logic [6:0] ROWS_RST = (MAX_ROWS < 64) ? 7'(MAX_ROWS) : 7'd64;

	logic [6:0] cols_q;
	logic [6:0] rows_q;
	logic       wr_en;

	// zero counts as one, above the maximum counts as the maximum
	function automatic logic [6:0] clamp7(input logic [6:0] v, input int unsigned mx);
		logic [6:0] r;
		if (v == 7'd0)
			r = 7'd1;
		else if (32'(v) > mx)
			r = 7'(mx);
		else
			r = v;
		return r;
	endfunction

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_RST;
			rows_q <= ROWS_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_COLUMNS)
				cols_q <= clamp7(pwdata[6:0], MAX_COLUMNS);
			else
				rows_q <= clamp7(pwdata[6:0], MAX_ROWS);
		end
	end

	// read back
	always_comb begin
		if (paddr[2] == REG_ROWS)
			prdata = {25'd0, rows_q};
		else
			prdata = {25'd0, cols_q};
	end

	assign cols = cols_q;
	assign rows = rows_q;
endmodule

@@ design/mbw_ctrl.sv @@
// Controller state machine sequencing start, step and read items.
module mbw_ctrl import mbw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  mbw_op_t  in_op,
	input  mbw_sts_t sts,
	output mbw_cmd_t cmd,
	output logic     in_ready
);
	mbw_state_t state_q;
	mbw_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (in_op)
						OP_START: state_d = ST_MUL;
						OP_STEP:  state_d = sts.done ? ST_RES_RD : ST_DIV_STEP;
						OP_READ:  state_d = ST_RES_RD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL:        state_d = ST_DIV_START;
			ST_DIV_START:  state_d = ST_WAIT_START;
			ST_WAIT_START: begin
				if (sts.div_done)
					state_d = ST_WIPE;
			end
			ST_WIPE: begin
				if (sts.clr_last)
					state_d = ST_RES_RD;
			end
			ST_DIV_STEP:   state_d = ST_WAIT_STEP;
			ST_WAIT_STEP: begin
				if (sts.div_done)
					state_d = ST_VISIT;
			end
			ST_VISIT:      state_d = ST_NB_RD;
			ST_NB_RD:      state_d = ST_NB_EVAL;
			ST_NB_EVAL:    state_d = sts.nb_last ? ST_PICK : ST_NB_RD;
			ST_PICK: begin
				if (!sts.n_zero)
					state_d = ST_PUSH;
				else if (!sts.depth_zero)
					state_d = ST_POP;
				else
					state_d = ST_RES_RD;
			end
			ST_PUSH:       state_d = ST_MOVE;
			ST_MOVE:       state_d = ST_RES_RD;
			ST_POP:        state_d = ST_RES_RD;
			ST_RES_RD:     state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free)
					state_d = ST_IDLE;
			end
			default:       state_d = ST_INIT;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT:       cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_MUL:        cmd.mul = 1'b1;
			ST_DIV_START:  cmd.div_go = 1'b1;
			ST_WAIT_START: cmd.set_start = sts.div_done;
			ST_WIPE:       cmd.clr_step = 1'b1;
			ST_DIV_STEP: begin
				cmd.div_go   = 1'b1;
				cmd.div_step = 1'b1;
			end
			ST_WAIT_STEP:  cmd.rd_cur = sts.div_done;
			ST_VISIT:      cmd.visit = 1'b1;
			ST_NB_RD:      cmd.nb_rd = 1'b1;
			ST_NB_EVAL:    cmd.nb_eval = 1'b1;
			ST_PICK: begin
				if (!sts.n_zero)
					cmd.pick = 1'b1;
				else if (!sts.depth_zero)
					cmd.pop_rd = 1'b1;
				else
					cmd.finish = 1'b1;
			end
			ST_PUSH:       cmd.push = 1'b1;
			ST_MOVE:       cmd.move = 1'b1;
			ST_POP:        cmd.pop = 1'b1;
			ST_RES_RD:     cmd.res_rd = 1'b1;
			ST_EMIT:       cmd.emit = sts.out_free;
			default:       cmd = '0;
		endcase
	end
endmodule

@@ design/mbw_dp.sv @@
// Datapath: cell store, path stack, divider, candidate list and result register.
module mbw_dp import mbw_pkg::*; #(
	parameter int STORE = 4096,
	parameter int IW    = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mbw_cmd_t    cmd,
	output mbw_sts_t    sts,
	input  logic [6:0]  cols,
	input  logic [6:0]  rows,
	input  mbw_op_t     in_op,
	input  logic [11:0] in_addr,
	input  logic [7:0]  in_rnd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_status,
	output logic [11:0] out_cell,
	output logic [3:0]  out_walls,
	output logic        out_visited
);
	localparam int CW = $clog2(STORE);
	localparam logic [IW:0] STORE_X   = (IW+1)'(STORE);
	localparam logic [CW:0] DEPTH_MAX = (CW+1)'(STORE);
	localparam logic [CW:0] CLR_LAST  = (CW+1)'(STORE - 1);

	// item and walk state
	mbw_op_t      op_q;
	logic [11:0]  addr_q;
	logic [7:0]   rnd_q;
	logic [IW-1:0] cur_q;
	logic [6:0]   x_q;
	logic [IW-1:0] y_q;
	logic [CW:0]  depth_q;
	logic         done_q;
	logic [CW:0]  clr_q;
	logic [13:0]  prod_q;
	logic [1:0]   dir_q;
	logic [2:0]   n_q;
	logic         pend_q;
	logic [IW-1:0] cand_cell_q [4];
	logic [4:0]   cand_val_q [4];
	logic [1:0]   cand_dir_q [4];
	logic [IW-1:0] next_q;
	logic [4:0]   nval_q;
	logic [3:0]   here_q;
	logic [3:0]   there_q;
	logic [4:0]   cur_val_q;
	logic [2:0]   res_stat_q;
	logic [IW-1:0] res_cell_q;
	logic         res_oor_q;
	logic         out_valid_q;
	logic [2:0]   out_status_q;
	logic [11:0]  out_cell_q;
	logic [3:0]   out_walls_q;
	logic         out_visited_q;

	// memory ports
	logic          c_we, c_re, s_we, s_re;
	logic [CW-1:0] c_waddr, c_raddr, s_waddr, s_raddr;
	logic [4:0]    c_wdata, c_rdata;
	logic [IW-1:0] s_rdata;

	// divider
	logic          div_done;
	logic [IW-1:0] div_quot;
	logic [13:0]   div_rem;

	// combinational helpers
	logic [IW:0]   cur_x, cols_x, nb_c;
	logic          nb_ok_c, nb_go;
	logic [IW-1:0] res_sel_c;
	logic          res_oor_c;
	logic [1:0]    k_c;
	logic [CW:0]   depth_m1;

	mbw_div #(.DW(IW), .VW(14)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (cmd.div_step ? cur_q : IW'(addr_q)),
		.divisor  (cmd.div_step ? {7'd0, cols} : prod_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	mbw_ram #(.WIDTH(5), .DEPTH(STORE)) u_cells (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	mbw_ram #(.WIDTH(IW), .DEPTH(STORE)) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (cur_q),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// neighbour of the current cell in direction dir_q
	assign cur_x  = {1'b0, cur_q};
	assign cols_x = (IW+1)'(cols);
	always_comb begin
		case (dir_q)
			DIR_UP: begin
				nb_ok_c = (y_q != '0);
				nb_c    = cur_x - cols_x;
			end
			DIR_LEFT: begin
				nb_ok_c = (x_q != 7'd0);
				nb_c    = cur_x - (IW+1)'(1);
			end
			DIR_DOWN: begin
				nb_ok_c = ((IW+1)'(y_q) + (IW+1)'(1)) < (IW+1)'(rows);
				nb_c    = cur_x + cols_x;
			end
			DIR_RIGHT: begin
				nb_ok_c = ({1'b0, x_q} + 8'd1) < {1'b0, cols};
				nb_c    = cur_x + (IW+1)'(1);
			end
			default: begin
				nb_ok_c = 1'b0;
				nb_c    = cur_x;
			end
		endcase
	end
	assign nb_go = nb_ok_c && (nb_c < STORE_X);

	// result cell: read address for a read item, else the current cell
	assign res_sel_c = (op_q == OP_READ) ? IW'(addr_q) : cur_q;
	assign res_oor_c = {1'b0, res_sel_c} >= STORE_X;

	assign k_c      = pick_index(rnd_q, n_q);
	assign depth_m1 = depth_q - (CW+1)'(1);

	// cell store port selection
	always_comb begin
		c_we    = 1'b0;
		c_waddr = cur_q[CW-1:0];
		c_wdata = {1'b0, WALLS_ALL};
		c_re    = 1'b0;
		c_raddr = cur_q[CW-1:0];
		if (cmd.clr_step) begin
			c_we    = 1'b1;
			c_waddr = clr_q[CW-1:0];
		end
		if (cmd.visit) begin
			c_we    = 1'b1;
			c_wdata = c_rdata | VISIT_MASK;
		end
		if (cmd.push) begin
			c_we    = 1'b1;
			c_wdata = cur_val_q & ~{1'b0, here_q};
		end
		if (cmd.move) begin
			c_we    = 1'b1;
			c_waddr = next_q[CW-1:0];
			c_wdata = (nval_q | VISIT_MASK) & ~{1'b0, there_q};
		end
		if (cmd.rd_cur)
			c_re = 1'b1;
		if (cmd.nb_rd) begin
			c_re    = nb_go;
			c_raddr = nb_c[CW-1:0];
		end
		if (cmd.res_rd) begin
			c_re    = !res_oor_c;
			c_raddr = res_sel_c[CW-1:0];
		end
	end

	// path stack ports; a push onto a full stack is dropped
	assign s_we    = cmd.push && (depth_q < DEPTH_MAX);
	assign s_waddr = depth_q[CW-1:0];
	assign s_re    = cmd.pop_rd;
	assign s_raddr = depth_m1[CW-1:0];

	// control and walk state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			depth_q     <= '0;
			done_q      <= 1'b1;
			clr_q       <= '0;
			dir_q       <= DIR_UP;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step)
				clr_q <= clr_q + (CW+1)'(1);
			if (cmd.set_start) begin
				cur_q   <= IW'(div_rem);
				done_q  <= 1'b0;
				depth_q <= '0;
				clr_q   <= '0;
			end
			if (cmd.visit) begin
				dir_q <= DIR_UP;
				n_q   <= '0;
			end
			if (cmd.nb_eval) begin
				dir_q <= dir_q + 2'd1;
				if (pend_q && !c_rdata[4])
					n_q <= n_q + 3'd1;
			end
			if (s_we)
				depth_q <= depth_q + (CW+1)'(1);
			if (cmd.move)
				cur_q <= next_q;
			if (cmd.pop_rd)
				depth_q <= depth_m1;
			if (cmd.pop)
				cur_q <= s_rdata;
			if (cmd.finish)
				done_q <= 1'b1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= in_op;
			addr_q <= in_addr;
			rnd_q  <= in_rnd;
			case (in_op)
				OP_START: res_stat_q <= RS_STARTED;
				OP_READ:  res_stat_q <= RS_READ_DONE;
				default:  res_stat_q <= RS_FINISHED;
			endcase
		end
		if (cmd.mul)
			prod_q <= {7'd0, cols} * {7'd0, rows};
		if (cmd.rd_cur) begin
			x_q <= div_rem[6:0];
			y_q <= div_quot;
		end
		if (cmd.visit)
			cur_val_q <= c_rdata | VISIT_MASK;
		if (cmd.nb_rd)
			pend_q <= nb_go;
		// collect an unvisited neighbour
		if (cmd.nb_eval && pend_q && !c_rdata[4]) begin
			cand_cell_q[n_q[1:0]] <= nb_c[IW-1:0];
			cand_val_q[n_q[1:0]]  <= c_rdata;
			cand_dir_q[n_q[1:0]]  <= dir_q;
		end
		if (cmd.pick) begin
			next_q  <= cand_cell_q[k_c];
			nval_q  <= cand_val_q[k_c];
			here_q  <= here_wall(cand_dir_q[k_c]);
			there_q <= there_wall(cand_dir_q[k_c]);
		end
		if (cmd.move)
			res_stat_q <= RS_ADVANCED;
		if (cmd.pop)
			res_stat_q <= RS_BACKTRACKED;
		if (cmd.finish)
			res_stat_q <= RS_FINISHED;
		if (cmd.res_rd) begin
			res_cell_q <= res_sel_c;
			res_oor_q  <= res_oor_c;
		end
		// cells beyond the store read as all walls, unvisited
		if (cmd.emit) begin
			out_status_q  <= res_stat_q;
			out_cell_q    <= res_cell_q[11:0];
			out_walls_q   <= res_oor_q ? WALLS_ALL : c_rdata[3:0];
			out_visited_q <= res_oor_q ? 1'b0 : c_rdata[4];
		end
	end

	// status to controller
	assign sts.done       = done_q;
	assign sts.clr_last   = (clr_q == CLR_LAST);
	assign sts.div_done   = div_done;
	assign sts.nb_last    = (dir_q == DIR_RIGHT);
	assign sts.n_zero     = (n_q == 3'd0);
	assign sts.depth_zero = (depth_q == '0);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_cell    = out_cell_q;
	assign out_walls   = out_walls_q;
	assign out_visited = out_visited_q;
endmodule

@@ design/maze_backtracker_walker_core.sv @@
// Top level of the depth-first maze walker: channels, registers, controller, datapath.
//
// Usage: items arrive on req (operation, cell_address, random_value) with a
// valid/ready transfer; each start, step or read item gives one result on rsp
// (status, cell_out, wall_bits, visited_flag). Operation code 3 is taken and
// dropped. Grid size comes from two APB registers (columns at 0x0, rows at
// 0x4), written by the user only while the block is idle; the block does not check.
// Items are taken one at a time. A step splits the current cell into x and y
// in the restoring divider, one bit of the IW-bit cell index (IW = 12 by
// default) at a time, then reads the four neighbours through the single read
// port of the cell store. A start rewrites all S = MAX_COLUMNS * MAX_ROWS
// entries of the cell store, one entry per cycle.
// Reset: the cell store is swept to all walls, unvisited, with req.ready low;
// APB writes are taken during the sweep.
// Stall: the result waits in an output register; a new item is taken while it
// waits, and the next result is held back until rsp.ready frees the register.
module maze_backtracker_walker_core import mbw_pkg::*; #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	mbw_req_if.sink     req,
	mbw_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int STORE = MAX_COLUMNS * MAX_ROWS;
	localparam int CW    = $clog2(STORE);
	localparam int IW    = (CW > 12) ? CW : 12;

	logic [6:0] cols;
	logic [6:0] rows;
	mbw_cmd_t   cmd;
	mbw_sts_t   sts;

	mbw_regs #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cols    (cols),
		.rows    (rows)
	);

	mbw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.operation),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (req.ready)
	);

	mbw_dp #(.STORE(STORE), .IW(IW)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cols        (cols),
		.rows        (rows),
		.in_op       (req.operation),
		.in_addr     (req.cell_address),
		.in_rnd      (req.random_value),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_status  (rsp.status),
		.out_cell    (rsp.cell_out),
		.out_walls   (rsp.wall_bits),
		.out_visited (rsp.visited_flag)
	);
endmodule

@@ design/mbw_checker.sv @@
// Port-level checker of the maze walker result channel, bound to the top level.
module mbw_checker import mbw_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [11:0] rsp_cell,
	input logic [3:0]  rsp_walls,
	input logic        rsp_visited
);
	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_cell)
			&& $stable(rsp_walls) && $stable(rsp_visited))
		else $error("result changed while stalled");

	// a fresh maze starts from a closed, unvisited cell
	a_start_closed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == RS_STARTED |-> rsp_walls == WALLS_ALL && !rsp_visited)
		else $error("start cell not cleared");

	// moves and backtracks land on visited cells
	a_walk_visited: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == RS_ADVANCED || rsp_status == RS_BACKTRACKED)
			|-> rsp_visited)
		else $error("walk landed on unvisited cell");

	// an advance always opens a wall of the entered cell
	a_advance_open: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == RS_ADVANCED |-> rsp_walls != WALLS_ALL)
		else $error("advance left entered cell closed");
endmodule

bind maze_backtracker_walker_core mbw_checker u_mbw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_cell    (rsp.cell_out),
	.rsp_walls   (rsp.wall_bits),
	.rsp_visited (rsp.visited_flag)
);
